// ===== rtl/carp_pkg.sv =====
`default_nettype none

package carp_pkg;

    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 1'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [3:0]  RETRY_RESET   = 4'd3;

    // message kinds
    localparam logic [1:0] MSG_NONE      = 2'd0;
    localparam logic [1:0] MSG_REPORT    = 2'd1;
    localparam logic [1:0] MSG_COMPLETED = 2'd2;
    localparam logic [1:0] MSG_ERROR     = 2'd3;

    // led bit positions
    localparam int LED_RED   = 0;
    localparam int LED_GREEN = 1;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [11:0] sample;
        logic [1:0]  leds;
    } msg_t;

    // decimal weight for digit position k (thousands first)
    function automatic logic [13:0] digit_weight(input logic [1:0] k);
        case (k)
            2'd0:    return 14'd1000;
            2'd1:    return 14'd100;
            default: return 14'd10;
        endcase
    endfunction

    // decimal digit of r at weight of position k, r below ten times the weight
    function automatic logic [3:0] digit_of(input logic [11:0] r, input logic [1:0] k);
        logic [13:0] w;
        logic [17:0] m;
        logic [3:0]  cnt;
        w   = digit_weight(k);
        cnt = 4'd0;
        for (int i = 1; i < 10; i++) begin
            m = w * 4'(i);
            if ({6'd0, r} >= m) begin
                cnt = cnt + 4'd1;
            end
        end
        return cnt;
    endfunction

    function automatic logic [7:0] completed_char(input logic [3:0] pos);
        case (pos)
            4'd0:    return "C";
            4'd1:    return "O";
            4'd2:    return "M";
            4'd3:    return "P";
            4'd4:    return "L";
            4'd5:    return "E";
            4'd6:    return "T";
            4'd7:    return "E";
            4'd8:    return "D";
            4'd9:    return 8'h0D;
            default: return 8'h0A;
        endcase
    endfunction

    function automatic logic [7:0] error_char(input logic [3:0] pos);
        case (pos)
            4'd0:    return "E";
            4'd1:    return "R";
            4'd2:    return "R";
            4'd3:    return "O";
            4'd4:    return "R";
            4'd5:    return 8'h0D;
            default: return 8'h0A;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/carp_control.sv =====
`default_nettype none

module carp_control (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            beat,
    input  wire logic                            opcode,
    input  wire logic [7:0]                      rx_byte,
    input  wire logic [11:0]                     adc_sample,
    input  wire logic                            cfg_wen,
    input  wire logic [carp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [carp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            msg_take,
    output carp_pkg::msg_t                       msg
);
    import carp_pkg::*;

    localparam logic [3:0] PS_IDLE     = 4'd0;
    localparam logic [3:0] PS_BANG     = 4'd1;
    localparam logic [3:0] PS_R        = 4'd2;
    localparam logic [3:0] PS_S        = 4'd3;
    localparam logic [3:0] PS_T        = 4'd4;
    localparam logic [3:0] PS_O        = 4'd5;
    localparam logic [3:0] PS_K        = 4'd6;
    localparam logic [3:0] PS_RST_HASH = 4'd7;
    localparam logic [3:0] PS_OK_HASH  = 4'd8;

    localparam logic [1:0] LS_IDLE  = 2'd0;
    localparam logic [1:0] LS_WAIT  = 2'd1;
    localparam logic [1:0] LS_ERROR = 2'd2;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_BAD  = 2'd1;
    localparam logic [1:0] EV_RST  = 2'd2;
    localparam logic [1:0] EV_OK   = 2'd3;

    logic [15:0] timeout_reg;
    logic [3:0]  limit_reg;
    logic [3:0]  parser_reg, parser_next;
    logic [1:0]  link_reg, link_next;
    logic [3:0]  retry_reg, retry_next;
    logic [15:0] wait_reg, wait_next;
    logic [1:0]  led_reg, led_next;
    msg_t        msg_reg, msg_next;

    logic       term;
    logic [1:0] ev;
    logic [7:0] expect_c;
    logic [3:0] match_state;
    logic [3:0] retry_inc;
    logic [1:0] kind;

    assign msg = msg_reg;

    always_comb begin
        term        = (rx_byte == 8'h0D) || (rx_byte == 8'h0A);
        ev          = EV_NONE;
        parser_next = parser_reg;
        expect_c    = 8'h00;
        match_state = parser_reg;
        case (parser_reg)
            PS_BANG: begin
                if (rx_byte == "R") begin
                    parser_next = PS_R;
                end else if (rx_byte == "O") begin
                    parser_next = PS_O;
                end else if (term) begin
                    parser_next = PS_IDLE;
                    ev          = EV_BAD;
                end
            end
            PS_R, PS_S, PS_T, PS_O, PS_K: begin
                case (parser_reg)
                    PS_R: begin
                        expect_c    = "S";
                        match_state = PS_S;
                    end
                    PS_S: begin
                        expect_c    = "T";
                        match_state = PS_T;
                    end
                    PS_T: begin
                        expect_c    = "#";
                        match_state = PS_RST_HASH;
                    end
                    PS_O: begin
                        expect_c    = "K";
                        match_state = PS_K;
                    end
                    default: begin
                        expect_c    = "#";
                        match_state = PS_OK_HASH;
                    end
                endcase
                if (rx_byte == expect_c) begin
                    parser_next = match_state;
                end else if (term) begin
                    parser_next = PS_IDLE;
                    ev          = EV_BAD;
                end
            end
            PS_RST_HASH: begin
                if (term) begin
                    parser_next = PS_IDLE;
                    ev          = EV_RST;
                end
            end
            PS_OK_HASH: begin
                if (term) begin
                    parser_next = PS_IDLE;
                    ev          = EV_OK;
                end
            end
            default: begin
                parser_next = (rx_byte == "!") ? PS_BANG : PS_IDLE;
            end
        endcase
    end

    always_comb begin
        link_next  = link_reg;
        retry_next = retry_reg;
        wait_next  = wait_reg;
        led_next   = led_reg;
        kind       = MSG_NONE;
        retry_inc  = retry_reg + 4'd1;
        if (!opcode) begin
            case (ev)
                EV_BAD: begin
                    link_next = LS_ERROR;
                end
                EV_RST: begin
                    kind = MSG_REPORT;
                end
                EV_OK: begin
                    retry_next = 4'd0;
                    link_next  = LS_IDLE;
                    kind       = MSG_COMPLETED;
                end
                default: begin
                end
            endcase
        end else if (link_reg == LS_WAIT) begin
            if (wait_reg > 16'd1) begin
                wait_next = wait_reg - 16'd1;
            end else begin
                wait_next = 16'd0;
                if (retry_inc >= limit_reg) begin
                    retry_next = 4'd0;
                    led_next   = 2'b00;
                    led_next[LED_GREEN] = 1'b1;
                    link_next  = LS_IDLE;
                    kind       = MSG_ERROR;
                end else begin
                    retry_next = retry_inc;
                    kind       = MSG_REPORT;
                end
            end
        end
        if (kind == MSG_REPORT) begin
            led_next = 2'b00;
            led_next[LED_RED] = 1'b1;
            wait_next = timeout_reg;
            link_next = LS_WAIT;
        end
        msg_next = msg_reg;
        if (msg_take) begin
            msg_next.valid = 1'b0;
        end
        if (kind != MSG_NONE) begin
            msg_next.valid  = 1'b1;
            msg_next.kind   = kind;
            msg_next.sample = adc_sample;
            msg_next.leds   = led_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= TIMEOUT_RESET;
            limit_reg     <= RETRY_RESET;
            parser_reg    <= PS_IDLE;
            link_reg      <= LS_IDLE;
            retry_reg     <= 4'd0;
            wait_reg      <= 16'd0;
            led_reg       <= 2'b00;
            msg_reg.valid <= 1'b0;
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_TIMEOUT_TICKS: timeout_reg <= cfg_wdata[15:0];
                    CFG_RETRY_LIMIT:   limit_reg   <= cfg_wdata[3:0];
                    default: begin
                    end
                endcase
            end
            if (beat) begin
                if (!opcode) begin
                    parser_reg <= parser_next;
                end
                link_reg  <= link_next;
                retry_reg <= retry_next;
                wait_reg  <= wait_next;
                led_reg   <= led_next;
                msg_reg   <= msg_next;
            end else if (msg_take) begin
                msg_reg.valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/carp_serializer.sv =====
`default_nettype none

module carp_serializer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  carp_pkg::msg_t  msg,
    output logic            msg_take,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      tx_char,
    output logic            last_char,
    output logic            led_red,
    output logic            led_green
);
    import carp_pkg::*;

    logic        busy_reg;
    logic [1:0]  kind_reg;
    logic [3:0]  pos_reg;
    logic [11:0] rem_reg;
    logic [3:0]  dig_reg [4];
    logic [1:0]  led_reg;

    logic [3:0]  nd;
    logic [3:0]  last_pos;
    logic [3:0]  dig_idx;
    logic [3:0]  digit;
    logic [13:0] w;
    logic [17:0] sub;
    logic        advance;

    always_comb begin
        if (dig_reg[0] != 4'd0) begin
            nd = 4'd4;
        end else if (dig_reg[1] != 4'd0) begin
            nd = 4'd3;
        end else if (dig_reg[2] != 4'd0) begin
            nd = 4'd2;
        end else begin
            nd = 4'd1;
        end
        case (kind_reg)
            MSG_COMPLETED: last_pos = 4'd10;
            MSG_ERROR:     last_pos = 4'd6;
            default:       last_pos = 4'd7 + nd;
        endcase
        dig_idx = pos_reg - 4'd1 - nd;
        case (kind_reg)
            MSG_COMPLETED: tx_char = completed_char(pos_reg);
            MSG_ERROR:     tx_char = error_char(pos_reg);
            default: begin
                case (pos_reg)
                    4'd0: tx_char = "!";
                    4'd1: tx_char = "A";
                    4'd2: tx_char = "D";
                    4'd3: tx_char = "C";
                    4'd4: tx_char = "=";
                    default: begin
                        if (pos_reg < 4'd5 + nd) begin
                            tx_char = 8'h30 | {4'd0, dig_reg[dig_idx[1:0]]};
                        end else if (pos_reg == 4'd5 + nd) begin
                            tx_char = "#";
                        end else if (pos_reg == 4'd6 + nd) begin
                            tx_char = 8'h0D;
                        end else begin
                            tx_char = 8'h0A;
                        end
                    end
                endcase
            end
        endcase
        // one decimal digit per prefix beat, thousands first
        digit = digit_of(rem_reg, pos_reg[1:0]);
        w     = digit_weight(pos_reg[1:0]);
        sub   = w * digit;
    end

    assign m_tvalid  = busy_reg;
    assign last_char = (pos_reg == last_pos);
    assign led_red   = led_reg[LED_RED];
    assign led_green = led_reg[LED_GREEN];
    assign advance   = busy_reg && m_tready;
    assign msg_take  = msg.valid && (!busy_reg || (advance && last_char));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= 4'd0;
        end else if (msg_take) begin
            busy_reg <= 1'b1;
            pos_reg  <= 4'd0;
        end else if (advance) begin
            if (last_char) begin
                busy_reg <= 1'b0;
            end
            pos_reg <= pos_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (msg_take) begin
            kind_reg <= msg.kind;
            rem_reg  <= msg.sample;
            led_reg  <= msg.leds;
        end else if (advance && kind_reg == MSG_REPORT && pos_reg < 4'd4) begin
            if (pos_reg == 4'd3) begin
                dig_reg[3] <= rem_reg[3:0];
            end else begin
                dig_reg[pos_reg[1:0]] <= digit;
                rem_reg <= rem_reg - sub[11:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/command_ack_retry_protocol_unit.sv =====
`default_nettype none

// Command/acknowledge/retry unit. Input beats carry either a received byte
// (tuser 0) or a timer tick (tuser 1); frames "!RST#" and "!OK#" closed by CR
// or LF are recognized. An input beat is decoded in the cycle it is accepted;
// a beat that causes a response places it in a one-entry holding register and
// the character serializer sends it one character per cycle while m_tready is
// high; a report "!ADC=<n>#\r\n" has 9 to 12 characters, COMPLETED 11 and ERROR 7.
// s_tready is high whenever the holding register is free, so beats that cause no
// response stream at one per cycle while it stays free, and a second response can
// be queued while the first is still being sent; the serializer's character rate
// sets the sustained rate for response-producing beats. LED levels in each output
// beat are those in force after the message. Configuration writes take effect
// at once and are expected only while the unit is idle.
module command_ack_retry_protocol_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // rx_byte [7:0], adc_sample [19:8], zero [23:20]
    input  wire logic [carp_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode [0]
    input  wire logic [0:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // tx_char [7:0], led_red [8], led_green [9], zero [15:10]
    output logic [carp_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast,
    input  wire logic                            cfg_wen,
    input  wire logic [carp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [carp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import carp_pkg::*;

    msg_t       msg;
    logic       msg_take;
    logic [7:0] tx_char;
    logic       led_red;
    logic       led_green;

    assign s_tready = !msg.valid;
    assign m_tdata  = {6'd0, led_green, led_red, tx_char};

    carp_control u_control (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat       (s_tvalid && s_tready),
        .opcode     (s_tuser[0]),
        .rx_byte    (s_tdata[7:0]),
        .adc_sample (s_tdata[19:8]),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .msg_take   (msg_take),
        .msg        (msg)
    );

    carp_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .msg       (msg),
        .msg_take  (msg_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .tx_char   (tx_char),
        .last_char (m_tlast),
        .led_red   (led_red),
        .led_green (led_green)
    );

endmodule

`default_nettype wire

// ===== rtl/carp_checker.sv =====
`default_nettype none

module carp_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [carp_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                            m_tlast
);
    import carp_pkg::*;

    // stalled beat stays offered
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output beat changed");

    // a message runs without gaps and with one LED setting
    a_msg_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[9:8] == $past(m_tdata[9:8])))
        else $error("message broken or LED levels changed inside a message");

    // a queued response means the serializer is busy
    a_queue_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> m_tvalid)
        else $error("response queued but nothing sent");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind command_ack_retry_protocol_unit carp_checker u_carp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== bench/tb_command_ack_retry_protocol_unit.sv =====
`default_nettype none

module tb_command_ack_retry_protocol_unit;

    import carp_pkg::*;

    localparam logic [7:0] CHR_CR      = 8'h0D;
    localparam logic [7:0] CHR_LF      = 8'h0A;
    localparam int         HOLD_CYCLES = 300;
    localparam int         SETTLE      = 4;

    typedef enum logic [3:0] {
        PRS_IDLE, PRS_BANG, PRS_R, PRS_S, PRS_T, PRS_O, PRS_K, PRS_RST_HASH, PRS_OK_HASH
    } parse_st_e;

    typedef enum logic [1:0] {LNK_IDLE, LNK_WAIT, LNK_ERROR} link_st_e;

    typedef enum logic [1:0] {EV_NONE, EV_BAD, EV_RST, EV_OK} frame_ev_e;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       red;
        logic       grn;
    } tx_char_t;

    typedef struct {
        row_kind_e   kind;
        bit          op;
        logic [7:0]  ch;    // register index for config rows
        logic [15:0] val;   // sample for item rows, register value for config rows
        bit          typed;
        string       txt;
        bit          red;
        bit          grn;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    wire logic             s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    wire logic             m_tvalid;
    logic                  m_tready;
    wire logic [M_TDATA_W-1:0] m_tdata;
    wire logic             m_tlast;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // shadow of the block
    parse_st_e   prs_st;
    link_st_e    lnk_st;
    logic [3:0]  retries;
    logic [15:0] wait_left;
    logic        led_r;
    logic        led_g;
    logic [15:0] cfg_timeout;
    logic [3:0]  cfg_limit;

    tx_char_t expected_chars[$];
    tx_char_t resp_chars[$];
    dir_row_t dir_rows[$];

    int  mismatches   = 0;
    int  beats_sent   = 0;
    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    bit  rx_hold_req  = 1'b0;

    command_ack_retry_protocol_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    // append a message body plus CR LF to the response being built
    task automatic emit(input string body, input bit red, input bit grn);
        tx_char_t c;
        int       i;
        c.red  = red;
        c.grn  = grn;
        c.last = 1'b0;
        for (i = 0; i < body.len(); i++) begin
            c.ch = body[i];
            resp_chars.push_back(c);
        end
        c.ch = CHR_CR;
        resp_chars.push_back(c);
        c.ch   = CHR_LF;
        c.last = 1'b1;
        resp_chars.push_back(c);
    endtask

    task automatic start_report(input logic [11:0] smp);
        led_r     = 1'b1;
        led_g     = 1'b0;
        wait_left = cfg_timeout;
        lnk_st    = LNK_WAIT;
        emit($sformatf("!ADC=%0d#", smp), 1'b1, 1'b0);
    endtask

    task automatic predict_response(input bit op, input logic [7:0] c, input logic [11:0] smp);
        frame_ev_e ev;
        bit        term;
        ev   = EV_NONE;
        term = (c == CHR_CR) || (c == CHR_LF);
        resp_chars.delete();
        if (!op) begin
            case (prs_st)
                PRS_BANG: begin
                    if (c == "R") prs_st = PRS_R;
                    else if (c == "O") prs_st = PRS_O;
                    else if (term) begin
                        prs_st = PRS_IDLE;
                        ev     = EV_BAD;
                    end
                end
                PRS_R, PRS_S, PRS_T, PRS_O, PRS_K: begin
                    if (prs_st == PRS_R && c == "S") prs_st = PRS_S;
                    else if (prs_st == PRS_S && c == "T") prs_st = PRS_T;
                    else if (prs_st == PRS_T && c == "#") prs_st = PRS_RST_HASH;
                    else if (prs_st == PRS_O && c == "K") prs_st = PRS_K;
                    else if (prs_st == PRS_K && c == "#") prs_st = PRS_OK_HASH;
                    else if (term) begin
                        prs_st = PRS_IDLE;
                        ev     = EV_BAD;
                    end
                end
                PRS_RST_HASH: begin
                    if (term) begin
                        prs_st = PRS_IDLE;
                        ev     = EV_RST;
                    end
                end
                PRS_OK_HASH: begin
                    if (term) begin
                        prs_st = PRS_IDLE;
                        ev     = EV_OK;
                    end
                end
                default: prs_st = (c == "!") ? PRS_BANG : PRS_IDLE;
            endcase
            case (ev)
                EV_BAD: lnk_st = LNK_ERROR;
                EV_RST: start_report(smp);
                EV_OK: begin
                    retries = 4'd0;
                    lnk_st  = LNK_IDLE;
                    emit("COMPLETED", led_r, led_g);
                end
                default: ;
            endcase
        end else if (lnk_st == LNK_WAIT) begin
            if (wait_left > 16'd1) begin
                wait_left = wait_left - 16'd1;
            end else begin
                wait_left = 16'd0;
                retries   = retries + 4'd1;
                if (retries >= cfg_limit) begin
                    retries = 4'd0;
                    led_r   = 1'b0;
                    led_g   = 1'b1;
                    lnk_st  = LNK_IDLE;
                    emit("ERROR", 1'b0, 1'b1);
                end else begin
                    start_report(smp);
                end
            end
        end
    endtask

    // offer one beat, predict it once accepted
    task automatic send_beat(input bit op, input logic [7:0] c, input logic [11:0] smp,
                             input bit typed, input string txt, input bit red, input bit grn);
        int i;
        while (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, smp, c};
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        predict_response(op, c, smp);
        if (typed) begin
            resp_chars.delete();
            if (txt.len() != 0) emit(txt, red, grn);
        end
        for (i = 0; i < resp_chars.size(); i++) expected_chars.push_back(resp_chars[i]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_chars.size() != 0) @(posedge aclk);
    endtask

    task automatic wait_idle();
        drain();
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        if (idx == CFG_TIMEOUT_TICKS) cfg_timeout = val;
        else cfg_limit = val[3:0];
    endtask

    function automatic logic [11:0] rand_sample();
        int span;
        case ($urandom_range(0, 3))
            0:       span = 9;
            1:       span = 99;
            2:       span = 999;
            default: span = 4095;
        endcase
        return 12'($urandom_range(0, span));
    endfunction

    // send "!" + the first cut characters of body + CR or LF, with scattered noise
    task automatic send_frame(input string body, input int cut);
        int i;
        for (i = -1; i < cut; i++) begin
            if ($urandom_range(1, 100) <= 8)
                send_beat(1'b0, 8'($urandom_range(0, 255)), rand_sample(), 0, "", 0, 0);
            send_beat(1'b0, (i < 0) ? 8'("!") : 8'(body[i]), rand_sample(), 0, "", 0, 0);
        end
        send_beat(1'b0, $urandom_range(0, 1) ? CHR_CR : CHR_LF, rand_sample(), 0, "", 0, 0);
    endtask

    task automatic add_row(input row_kind_e kind, input bit op, input logic [7:0] c,
                           input logic [15:0] val, input bit typed, input string txt,
                           input bit red, input bit grn);
        dir_row_t r;
        r.kind  = kind;
        r.op    = op;
        r.ch    = c;
        r.val   = val;
        r.typed = typed;
        r.txt   = txt;
        r.red   = red;
        r.grn   = grn;
        dir_rows.push_back(r);
    endtask

    task automatic run_phase(input logic [15:0] tmo, input logic [3:0] lim, input int tx_pct,
                             input int rx_pct, input int n_beats, input bit hold,
                             input bit pause);
        int start;
        int k;
        bit paused;
        paused = 1'b0;
        wait_idle();
        write_reg(CFG_TIMEOUT_TICKS, tmo);
        write_reg(CFG_RETRY_LIMIT, {12'($urandom_range(0, 4095)), lim});
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (hold) rx_hold_req = 1'b1;
        start = beats_sent;
        while (beats_sent - start < n_beats) begin
            if (pause && !paused && beats_sent - start >= n_beats / 2) begin
                paused = 1'b1;
                drain();
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 9: send_frame("RST#", 4);
                3:          send_frame("OK#", 3);
                4: begin
                    if ($urandom_range(0, 1)) send_frame("RST#", $urandom_range(0, 3));
                    else send_frame("OK#", $urandom_range(0, 2));
                end
                5, 6, 7: begin
                    for (k = (($urandom_range(0, 2) == 0) ? $urandom_range(8, 24)
                                                          : $urandom_range(1, 6));
                         k > 0; k--) begin
                        send_beat(1'b1, 8'($urandom_range(0, 255)), rand_sample(), 0, "", 0, 0);
                    end
                end
                default:
                    send_beat(1'b0, 8'($urandom_range(0, 255)), rand_sample(), 0, "", 0, 0);
            endcase
        end
    endtask

    task automatic note_fail(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= !(rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : tx_check
        tx_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                note_fail($sformatf("unexpected beat: char %02h last %0b leds %02b",
                                    m_tdata[7:0], m_tlast, m_tdata[9:8]));
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata[7:0] !== want.ch || m_tlast !== want.last ||
                    m_tdata[8] !== want.red || m_tdata[9] !== want.grn) begin
                    note_fail($sformatf(
                        "mismatch: exp char %02h last %0b red %0b green %0b, got %02h %0b %0b %0b",
                        want.ch, want.last, want.red, want.grn,
                        m_tdata[7:0], m_tlast, m_tdata[8], m_tdata[9]));
                end
            end
        end
    end

    initial begin : stimulus
        dir_row_t r;
        int       k;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_wen   <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        prs_st      = PRS_IDLE;
        lnk_st      = LNK_IDLE;
        retries     = 4'd0;
        wait_left   = 16'd0;
        led_r       = 1'b0;
        led_g       = 1'b0;
        cfg_timeout = TIMEOUT_RESET;
        cfg_limit   = RETRY_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE) @(posedge aclk);

        // stray byte in idle, then OK while not waiting
        add_row(ROW_ITEM, 0, 8'hFF, 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, "!", 16'h123, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, "O", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, "K", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, "#", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, CHR_CR, 16'h000, 1, "COMPLETED", 0, 0);
        // RST with a stray byte inside the frame, largest sample
        add_row(ROW_ITEM, 0, "!", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, "R", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, 8'h00, 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, "S", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, "T", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, "#", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, CHR_LF, 16'hFFF, 1, "!ADC=4095#", 1, 0);
        // malformed frame cancels the wait; the tick after it is dropped
        add_row(ROW_ITEM, 0, "!", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, "R", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, CHR_CR, 16'h000, 1, "", 0, 0);
        add_row(ROW_ITEM, 1, 8'h00, 16'hFFF, 1, "", 0, 0);
        // zero timeout and zero retry limit: first tick reports ERROR
        add_row(ROW_CFG, 0, 8'(CFG_TIMEOUT_TICKS), 16'd0, 0, "", 0, 0);
        add_row(ROW_CFG, 0, 8'(CFG_RETRY_LIMIT), 16'd0, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, "!", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, "R", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, "S", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, "T", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, "#", 16'h000, 0, "", 0, 0);
        add_row(ROW_ITEM, 0, CHR_LF, 16'h000, 1, "!ADC=0#", 1, 0);
        add_row(ROW_ITEM, 1, 8'hFF, 16'h5A5, 1, "ERROR", 0, 1);

        for (k = 0; k < dir_rows.size(); k++) begin
            r = dir_rows[k];
            if (r.kind == ROW_CFG) begin
                wait_idle();
                write_reg(r.ch[CFG_IDX_W-1:0], r.val);
            end else begin
                send_beat(r.op, r.ch, r.val[11:0], r.typed, r.txt, r.red, r.grn);
            end
        end

        run_phase(16'd1,     4'd1,  0,  0,  28, 0, 0);
        run_phase(16'd2,     4'd3,  68, 0,  28, 0, 0);
        run_phase(16'd65535, 4'd15, 0,  68, 28, 0, 0);
        run_phase(16'd0,     4'd0,  20, 20, 28, 0, 0);
        run_phase(16'd3,     4'd5,  0,  0,  28, 1, 0);
        run_phase(16'd1,     4'd2,  20, 20, 28, 0, 1);

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
